### src/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and constants of the sensor level and trend block.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  parameter int HALF_WINDOW = 3;
  parameter int RING_DEPTH  = 2 * HALF_WINDOW;

  parameter int SAMPLE_IN_W = 16;
  parameter int SAMPLE_W    = 12;
  parameter int LIMIT_W     = 13;
  parameter int TLIMIT_W    = 12;
  parameter int CODE_W      = 2;

  // sum of one half window and the reciprocal used for its floored mean
  parameter int SUM_W  = SAMPLE_W + $clog2(HALF_WINDOW);
  parameter int DIV_SH = SUM_W + $clog2(HALF_WINDOW);
  parameter int MUL_W  = DIV_SH + 1;
  parameter int PROD_W = SUM_W + MUL_W;
  parameter longint unsigned DIV_MUL_L =
    ((64'd1 << DIV_SH) + HALF_WINDOW - 1) / HALF_WINDOW;
  parameter logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);

  parameter int FILL_W = $clog2(RING_DEPTH + 1);

  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED     = 3'd0,
    CFG_BAND_LOW    = 3'd1,
    CFG_BAND_MID    = 3'd2,
    CFG_BAND_HIGH   = 3'd3,
    CFG_TREND_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    STATUS_OFFLINE = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    LEVEL_LOW       = 2'd0,
    LEVEL_MEDIUM    = 2'd1,
    LEVEL_HIGH      = 2'd2,
    LEVEL_VERY_HIGH = 2'd3
  } level_t;

  typedef enum logic [CODE_W-1:0] {
    TREND_STABLE  = 2'd0,
    TREND_RISING  = 2'd1,
    TREND_FALLING = 2'd2
  } trend_t;

  parameter logic [LIMIT_W-1:0]  BAND_LOW_RST    = 13'd1000;
  parameter logic [LIMIT_W-1:0]  BAND_MID_RST    = 13'd2000;
  parameter logic [LIMIT_W-1:0]  BAND_HIGH_RST   = 13'd3000;
  parameter logic [TLIMIT_W-1:0] TREND_LIMIT_RST = 12'd150;

  typedef struct packed {
    logic                enabled;
    logic [LIMIT_W-1:0]  band_low;
    logic [LIMIT_W-1:0]  band_mid;
    logic [LIMIT_W-1:0]  band_high;
    logic [TLIMIT_W-1:0] trend_limit;
  } cfg_t;

  typedef struct packed {
    status_t             status;
    logic [SAMPLE_W-1:0] last_value;
    level_t              level;
    trend_t              trend;
  } result_t;

  // floored mean of one half window: reciprocal multiply, exact for all sums
  function automatic logic [SAMPLE_W-1:0] half_mean(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV_MUL);
    return SAMPLE_W'(prod >> DIV_SH);
  endfunction

endpackage

`default_nettype wire

### src/slt_in_if.sv
// ----------------------------------------------------------------------------
// slt_in_if
// Sample request channel: valid, ready and one raw converter reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_in_if import slt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_IN_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### src/slt_out_if.sv
// ----------------------------------------------------------------------------
// slt_out_if
// Result request channel: valid, ready, status and held value, level and trend.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_out_if import slt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   status;
  logic [SAMPLE_W-1:0] last_value;
  logic [CODE_W-1:0]   level;
  logic [CODE_W-1:0]   trend;

  modport source (output valid, output status, output last_value, output level,
                  output trend, input ready);
  modport sink   (input valid, input status, input last_value, input level,
                  input trend, output ready);
endinterface

`default_nettype wire

### src/slt_cfg_if.sv
// ----------------------------------------------------------------------------
// slt_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_cfg_if import slt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/slt_cfg_regs.sv
// ----------------------------------------------------------------------------
// slt_cfg_regs
// Configuration register file; writes are always taken, unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cfg_regs import slt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  slt_cfg_if.sink   cfg_bus,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_ENABLED:     cfg_nxt.enabled     = cfg_bus.data[0];
        CFG_BAND_LOW:    cfg_nxt.band_low    = cfg_bus.data;
        CFG_BAND_MID:    cfg_nxt.band_mid    = cfg_bus.data;
        CFG_BAND_HIGH:   cfg_nxt.band_high   = cfg_bus.data;
        CFG_TREND_LIMIT: cfg_nxt.trend_limit = cfg_bus.data[TLIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled     <= 1'b1;
      cfg_r.band_low    <= BAND_LOW_RST;
      cfg_r.band_mid    <= BAND_MID_RST;
      cfg_r.band_high   <= BAND_HIGH_RST;
      cfg_r.trend_limit <= TREND_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### src/slt_core.sv
// ----------------------------------------------------------------------------
// slt_core
// Sample history, running half-window sums and held results; computes the
// result of the registered sample; an ok sample commits state when taken.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_core import slt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [SAMPLE_IN_W-1:0] sample,
  input  cfg_t                        cfg,
  output result_t                     res
);

  // history_r[0] is the newest sample
  logic [SAMPLE_W-1:0] history_r [RING_DEPTH];
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [SUM_W-1:0]    newer_sum_r;
  logic [SUM_W-1:0]    newer_sum_nxt;
  logic [SUM_W-1:0]    older_sum_r;
  logic [SUM_W-1:0]    older_sum_nxt;
  logic [SAMPLE_W-1:0] held_value_r;
  level_t              held_level_r;
  trend_t              held_trend_r;

  logic [SAMPLE_W-1:0] v;
  logic                sample_ok;
  status_t             status;
  level_t              level;
  trend_t              trend;
  logic [SAMPLE_W-1:0] newer_mean;
  logic [SAMPLE_W-1:0] older_mean;
  logic                commit;

  assign v         = sample[SAMPLE_W-1:0];
  assign sample_ok = (sample[SAMPLE_IN_W-1:SAMPLE_W] == '0);

  always_comb begin
    if (!cfg.enabled)   status = STATUS_OFFLINE;
    else if (!sample_ok) status = STATUS_INVALID;
    else                status = STATUS_OK;
  end

  always_comb begin
    if ({1'b0, v} < cfg.band_low)       level = LEVEL_LOW;
    else if ({1'b0, v} < cfg.band_mid)  level = LEVEL_MEDIUM;
    else if ({1'b0, v} < cfg.band_high) level = LEVEL_HIGH;
    else                                level = LEVEL_VERY_HIGH;
  end

  // sample leaving the newer half enters the older half
  assign newer_sum_nxt = SUM_W'({1'b0, newer_sum_r} + (SUM_W+1)'(v)
                                - (SUM_W+1)'(history_r[HALF_WINDOW-1]));
  assign older_sum_nxt = SUM_W'({1'b0, older_sum_r}
                                + (SUM_W+1)'(history_r[HALF_WINDOW-1])
                                - (SUM_W+1)'(history_r[RING_DEPTH-1]));
  assign fill_nxt = (fill_r == FILL_W'(RING_DEPTH)) ? fill_r : fill_r + 1'b1;

  assign newer_mean = half_mean(newer_sum_nxt);
  assign older_mean = half_mean(older_sum_nxt);

  always_comb begin
    if (fill_nxt != FILL_W'(RING_DEPTH))
      trend = TREND_STABLE;
    else if ({2'b0, newer_mean} > ({2'b0, older_mean} + {2'b0, cfg.trend_limit}))
      trend = TREND_RISING;
    else if ({2'b0, older_mean} > ({2'b0, newer_mean} + {2'b0, cfg.trend_limit}))
      trend = TREND_FALLING;
    else
      trend = TREND_STABLE;
  end

  always_comb begin
    res.status = status;
    if (status == STATUS_OK) begin
      res.last_value = v;
      res.level      = level;
      res.trend      = trend;
    end else begin
      res.last_value = held_value_r;
      res.level      = held_level_r;
      res.trend      = held_trend_r;
    end
  end

  assign commit = step && (status == STATUS_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) history_r[i] <= '0;
      fill_r       <= '0;
      newer_sum_r  <= '0;
      older_sum_r  <= '0;
      held_value_r <= '0;
      held_level_r <= LEVEL_LOW;
      held_trend_r <= TREND_STABLE;
    end else if (commit) begin
      history_r[0] <= v;
      for (int i = 1; i < RING_DEPTH; i++) history_r[i] <= history_r[i-1];
      fill_r       <= fill_nxt;
      newer_sum_r  <= newer_sum_nxt;
      older_sum_r  <= older_sum_nxt;
      held_value_r <= v;
      held_level_r <= level;
      held_trend_r <= trend;
    end
  end

endmodule

`default_nettype wire

### src/sensor_level_and_trend.sv
// ----------------------------------------------------------------------------
// sensor_level_and_trend
// Level bands and moving-window trend for a stream of raw converter samples.
// ----------------------------------------------------------------------------
// One request in gives one result out. The block takes a sample in every cycle
// unless the output stalls (input register, then result register); the trend
// comes from two running half-window sums that each sample updates in one
// step, so nothing loops per item. Disabled operation gives status offline, a
// reading above 4095 gives status invalid; both repeat the held value, level
// and trend. The user writes configuration only while the block holds no
// pending request; the block does not enforce it.
`default_nettype none

module sensor_level_and_trend import slt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  slt_in_if.sink    in_bus,
  slt_out_if.source out_bus,
  slt_cfg_if.sink   cfg_bus
);

  cfg_t                   cfg;
  result_t                res;
  logic                   in_valid_r;
  logic [SAMPLE_IN_W-1:0] in_sample_r;
  logic                   out_valid_r;
  result_t                out_res_r;
  logic                   adv;

  assign adv          = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || adv;

  slt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  slt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .sample (in_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) in_sample_r <= in_bus.sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_res_r.status;
  assign out_bus.last_value = out_res_r.last_value;
  assign out_bus.level      = out_res_r.level;
  assign out_bus.trend      = out_res_r.trend;

endmodule

`default_nettype wire

### src/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks of the sensor level and trend block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker import slt_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [CODE_W-1:0]   out_status,
  input wire logic [SAMPLE_W-1:0] out_last_value,
  input wire logic [CODE_W-1:0]   out_level,
  input wire logic [CODE_W-1:0]   out_trend
);

  logic [SAMPLE_W-1:0] prev_value_r;
  logic [CODE_W-1:0]   prev_level_r;
  logic [CODE_W-1:0]   prev_trend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_value_r <= '0;
      prev_level_r <= '0;
      prev_trend_r <= '0;
    end else if (out_valid && out_ready) begin
      prev_value_r <= out_last_value;
      prev_level_r <= out_level;
      prev_trend_r <= out_trend;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_last_value)
                               && $stable(out_level) && $stable(out_trend))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
      (out_last_value == prev_value_r) && (out_level == prev_level_r)
      && (out_trend == prev_trend_r))
    else $error("offline or invalid result changed held fields");

endmodule

bind sensor_level_and_trend slt_checker u_slt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_status     (out_bus.status),
  .out_last_value (out_bus.last_value),
  .out_level      (out_bus.level),
  .out_trend      (out_bus.trend)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor level and trend block.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the thresholds, the sample ring and the
// held value, level and trend. It predicts one result per accepted request
// and compares every returned result field by field. A short directed part
// covers band edges, invalid and disabled requests, unordered and extreme
// limits, masked and unknown register writes. Random rounds follow, mostly
// ramp-shaped sample streams, under several limit settings and idle
// patterns, including one long result hold-off.
// ----------------------------------------------------------------------------

import slt_pkg::*;

class level_trend_scoreboard;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  logic                enabled;
  logic [LIMIT_W-1:0]  band_low;
  logic [LIMIT_W-1:0]  band_mid;
  logic [LIMIT_W-1:0]  band_high;
  logic [TLIMIT_W-1:0] trend_limit;
  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  int                  write_pos;
  int                  fill_count;
  logic [SAMPLE_W-1:0] held_value;
  level_t              held_level;
  trend_t              held_trend;
  result_t             expected_q[$];
  int                  errors;

  function new();
    enabled     = 1'b1;
    band_low    = BAND_LOW_RST;
    band_mid    = BAND_MID_RST;
    band_high   = BAND_HIGH_RST;
    trend_limit = TREND_LIMIT_RST;
    foreach (ring[i]) ring[i] = '0;
    write_pos   = 0;
    fill_count  = 0;
    held_value  = '0;
    held_level  = LEVEL_LOW;
    held_trend  = TREND_STABLE;
    errors      = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLED:     enabled     = data[0];
      CFG_BAND_LOW:    band_low    = LIMIT_W'(data);
      CFG_BAND_MID:    band_mid    = LIMIT_W'(data);
      CFG_BAND_HIGH:   band_high   = LIMIT_W'(data);
      CFG_TREND_LIMIT: trend_limit = TLIMIT_W'(data);
      default: ;
    endcase
  endfunction

  function level_t classify_level(logic [SAMPLE_W-1:0] v);
    if (v < band_low)  return LEVEL_LOW;
    if (v < band_mid)  return LEVEL_MEDIUM;
    if (v < band_high) return LEVEL_HIGH;
    return LEVEL_VERY_HIGH;
  endfunction

  // push into the ring, then compare the half-window floored means
  function trend_t push_and_trend(logic [SAMPLE_W-1:0] v);
    int older;
    int newer;
    int slot;
    int diff;
    ring[write_pos] = v;
    write_pos = (write_pos + 1 >= RING_DEPTH) ? 0 : write_pos + 1;
    if (fill_count < RING_DEPTH) fill_count++;
    if (fill_count < RING_DEPTH) return TREND_STABLE;
    older = 0;
    newer = 0;
    slot  = write_pos;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (i < HALF_WINDOW) older += int'(ring[slot]);
      else newer += int'(ring[slot]);
      slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
    end
    diff = newer / HALF_WINDOW - older / HALF_WINDOW;
    if (diff > int'(trend_limit))  return TREND_RISING;
    if (diff < -int'(trend_limit)) return TREND_FALLING;
    return TREND_STABLE;
  endfunction

  function void note_sample(logic [SAMPLE_IN_W-1:0] s);
    result_t r;
    if (!enabled) begin
      r.status = STATUS_OFFLINE;
    end else if (s > SAMPLE_MAX) begin
      r.status = STATUS_INVALID;
    end else begin
      r.status   = STATUS_OK;
      held_value = SAMPLE_W'(s);
      held_level = classify_level(held_value);
      held_trend = push_and_trend(held_value);
    end
    r.last_value = held_value;
    r.level      = held_level;
    r.trend      = held_trend;
    expected_q.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("result with no request pending: status %0d value %0d",
             got.status, got.last_value);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.last_value !== want.last_value) begin
      $error("last_value: expected %0d, got %0d", want.last_value, got.last_value);
      errors++;
    end
    if (got.level !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, got.level);
      errors++;
    end
    if (got.trend !== want.trend) begin
      $error("trend: expected %0d, got %0d", want.trend, got.trend);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int ROUNDS      = 8;
  localparam int ROUND_ITEMS = 130;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 3'd7;
  localparam cfg_t DEFAULT_CFG = '{1'b1, BAND_LOW_RST, BAND_MID_RST, BAND_HIGH_RST,
                                   TREND_LIMIT_RST};

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   quiet;
  bit   hold_req;
  int   walk_level;
  int   walk_slope;
  level_trend_scoreboard sb;

  slt_in_if  in_bus();
  slt_out_if out_bus();
  slt_cfg_if cfg_bus();

  sensor_level_and_trend u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) sb.note_sample(in_bus.sample);
      if (out_bus.valid && out_bus.ready) begin
        got.status     = status_t'(out_bus.status);
        got.last_value = out_bus.last_value;
        got.level      = level_t'(out_bus.level);
        got.trend      = trend_t'(out_bus.trend);
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic push_sample(input logic [SAMPLE_IN_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_seq(input logic [SAMPLE_IN_W-1:0] seq[$]);
    foreach (seq[i]) push_sample(seq[i]);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // leaves valid high so back-to-back writes need no gap; cfg_done lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_config(input cfg_t c);
    cfg_write(CFG_ENABLED, CFG_DATA_W'(c.enabled));
    cfg_write(CFG_BAND_LOW, c.band_low);
    cfg_write(CFG_BAND_MID, c.band_mid);
    cfg_write(CFG_BAND_HIGH, c.band_high);
    cfg_write(CFG_TREND_LIMIT, CFG_DATA_W'(c.trend_limit));
    cfg_done();
  endtask

  function automatic cfg_t random_config(input bit ordered);
    int   a;
    int   b;
    int   c;
    int   t;
    cfg_t cfg;
    a = $urandom_range(4096);
    b = $urandom_range(4096);
    c = $urandom_range(4096);
    if (ordered) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    cfg.enabled     = 1'b1;
    cfg.band_low    = LIMIT_W'(a);
    cfg.band_mid    = LIMIT_W'(b);
    cfg.band_high   = LIMIT_W'(c);
    cfg.trend_limit = ($urandom_range(4) == 0) ? TLIMIT_W'($urandom_range(4095))
                                               : TLIMIT_W'($urandom_range(400));
    return cfg;
  endfunction

  // mostly a ramping walk so the trend swings; some noise and bad readings
  function automatic logic [SAMPLE_IN_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return SAMPLE_IN_W'($urandom_range(65535, 4096));
    if (pick < 14) return SAMPLE_IN_W'($urandom_range(4095));
    if ($urandom_range(9) == 0) walk_slope = int'($urandom_range(800)) - 400;
    walk_level += walk_slope + int'($urandom_range(100)) - 50;
    if (walk_level < 0) begin
      walk_level = 0;
      walk_slope = -walk_slope;
    end else if (walk_level > 4095) begin
      walk_level = 4095;
      walk_slope = -walk_slope;
    end
    return SAMPLE_IN_W'(walk_level);
  endfunction

  task automatic send_random(input int n);
    repeat (n) push_sample(next_sample());
  endtask

  task automatic directed_part();
    // band edges, fill, rising then falling then flat
    send_seq('{16'd0, 16'hFFFF, 16'd4096, 16'd999, 16'd1000, 16'd1999, 16'd2000,
               16'd2999, 16'd3000, 16'd4095, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
               16'd0});
    drain();
    cfg_write(CFG_ENABLED, 13'h1FFE);
    cfg_done();
    send_seq('{16'd500, 16'hFFFF});
    drain();
    // unordered limits, masked trend limit, write to a missing register
    cfg_write(CFG_ENABLED, 13'h0001);
    cfg_write(CFG_BAND_LOW, 13'd3000);
    cfg_write(CFG_BAND_MID, 13'd1000);
    cfg_write(CFG_BAND_HIGH, 13'd2000);
    cfg_write(CFG_TREND_LIMIT, 13'h1000);
    cfg_write(CFG_NO_SUCH_REG, 13'h1FFF);
    cfg_done();
    send_seq('{16'd500, 16'd1500, 16'd2500, 16'd3500, 16'd3501});
    drain();
    cfg_write(CFG_BAND_LOW, 13'd0);
    cfg_write(CFG_BAND_MID, 13'd0);
    cfg_write(CFG_BAND_HIGH, 13'h1FFF);
    cfg_write(CFG_TREND_LIMIT, 13'd4095);
    cfg_done();
    send_seq('{16'd0, 16'd4095, 16'd4095});
    drain();
    cfg_write(CFG_BAND_LOW, 13'd4096);
    cfg_done();
    send_seq('{16'd4095});
  endtask

  initial begin
    cfg_t cfg;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_ENABLED;
    cfg_bus.data   = '0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    hold_req       = 1'b0;
    quiet          = 0;
    walk_level     = 2048;
    walk_slope     = 0;
    sb             = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed_part();

    for (int round = 0; round < ROUNDS; round++) begin
      drain();
      case (round)
        0:       cfg = DEFAULT_CFG;
        1:       cfg = '{1'b1, 13'd0, 13'd4096, 13'd4096, 12'd0};
        2:       cfg = '{1'b1, 13'd4096, 13'd4096, 13'h1FFF, 12'd4095};
        default: cfg = random_config(round != 5);
      endcase
      write_config(cfg);
      case (round % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 80; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 80; end
        default: begin in_idle_pct = 38; out_stall_pct = 38; end
      endcase
      if (round == 4) hold_req = 1'b1;
      if (round == 6) begin
        send_random(ROUND_ITEMS / 2);
        drain();
        cfg_write(CFG_ENABLED, 13'd0);
        cfg_done();
        send_random(20);
        drain();
        cfg_write(CFG_ENABLED, 13'd1);
        cfg_done();
        send_random(ROUND_ITEMS / 2);
      end else begin
        send_random(ROUND_ITEMS);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
src/slt_pkg.sv
src/slt_in_if.sv
src/slt_out_if.sv
src/slt_cfg_if.sv
src/slt_cfg_regs.sv
src/slt_core.sv
src/sensor_level_and_trend.sv
src/slt_checker.sv
verif/testbench.sv
